// ----- hdl/ssm_pkg.sv -----
// Shared types and constants for the saturating stream mixer.
// Depends on nothing; imported by ssm_sat_add, saturating_stream_mixer_core and the testbench.
`default_nettype none

package ssm_pkg;

   // Sample width codes; the unused code behaves as 32 bits.
   localparam logic [1:0] WIDTH_CODE_8  = 2'd0;
   localparam logic [1:0] WIDTH_CODE_16 = 2'd1;
   localparam logic [1:0] WIDTH_CODE_32 = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_SAMPLE_WIDTH = 1'b0;
   localparam logic CSR_SIGNED       = 1'b1;

   localparam logic [31:0] MASK_8  = 32'h0000_00ff;
   localparam logic [31:0] MASK_16 = 32'h0000_ffff;
   localparam logic [31:0] MASK_32 = 32'hffff_ffff;

   typedef struct packed {
      logic [31:0] sample_bits;
      logic        first_stream;
      logic        last_stream;
      logic        gap_marked;
   } ssm_req_type;

   typedef struct packed {
      logic [31:0] mixed_sample;
      logic        all_silent;
   } ssm_rsp_type;

   typedef struct packed {
      logic [1:0] sample_width_code;
      logic       signed_samples;
   } ssm_cfg_type;

   function automatic logic [31:0] width_mask(input logic [1:0] code);
      logic [31:0] m;
      case (code)
         WIDTH_CODE_8:  m = MASK_8;
         WIDTH_CODE_16: m = MASK_16;
         default:       m = MASK_32;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ssm_sat_add.sv -----
// Saturating add of two raw samples in the configured width and signedness.
// Depends on ssm_pkg for the configuration struct and width masks.
`default_nettype none

module ssm_sat_add
   import ssm_pkg::*;
(
   input  wire ssm_cfg_type  cfg,
   input  wire logic [31:0]  a,
   input  wire logic [31:0]  b,
   output logic      [31:0]  sum
);

   logic        [31:0] mask;
   logic        [31:0] a_m;
   logic        [31:0] b_m;
   logic signed [33:0] a_s;
   logic signed [33:0] b_s;
   logic signed [33:0] sum_s;
   logic signed [33:0] hi_s;
   logic signed [33:0] lo_s;
   logic signed [33:0] clamp_s;
   logic        [32:0] sum_u;

   always_comb begin
      mask = width_mask(cfg.sample_width_code);
      a_m  = a & mask;
      b_m  = b & mask;
      // sign-extend from the top bit of the active width
      case (cfg.sample_width_code)
         WIDTH_CODE_8: begin
            a_s = {{26{a_m[7]}}, a_m[7:0]};
            b_s = {{26{b_m[7]}}, b_m[7:0]};
         end
         WIDTH_CODE_16: begin
            a_s = {{18{a_m[15]}}, a_m[15:0]};
            b_s = {{18{b_m[15]}}, b_m[15:0]};
         end
         default: begin
            a_s = {{2{a_m[31]}}, a_m};
            b_s = {{2{b_m[31]}}, b_m};
         end
      endcase
      sum_s = a_s + b_s;
      hi_s  = {2'b00, 1'b0, mask[31:1]};
      lo_s  = ~hi_s;
      if (sum_s > hi_s) begin
         clamp_s = hi_s;
      end else if (sum_s < lo_s) begin
         clamp_s = lo_s;
      end else begin
         clamp_s = sum_s;
      end
      sum_u = {1'b0, a_m} + {1'b0, b_m};
      if (cfg.signed_samples) begin
         sum = clamp_s[31:0] & mask;
      end else if (sum_u > {1'b0, mask}) begin
         sum = mask;
      end else begin
         sum = sum_u[31:0];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/saturating_stream_mixer_core.sv -----
// Saturating stream mixer: accumulates one sample position over N streams.
// A last-stream word passes the input register, then the result register, to its result word.
// Throughput: one input word per cycle, sustained, while results are taken.
// The accumulator feedback is a single combinational saturating add.
// Reset (synchronous, active high): empty pipeline, sum zero, silent set,
// width 16 bits, signed samples.
// Depends on ssm_pkg and ssm_sat_add.
`default_nettype none

module saturating_stream_mixer_core
   import ssm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input word channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ssm_req_type req_payload,
   // result word channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ssm_rsp_type      rsp_payload,
   // configuration write port
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [1:0]  csr_write_data
);

   // configuration registers
   ssm_cfg_type cfg_ff, cfg_in;

   // input stage
   logic        in_valid_ff, in_valid_in;
   ssm_req_type in_ff, in_in;

   // accumulator state
   logic [31:0] sum_ff, sum_in;
   logic        silent_ff, silent_in;

   // result stage
   logic        out_valid_ff, out_valid_in;
   ssm_rsp_type out_ff, out_in;

   logic        out_free;
   logic        proc;
   logic        emit;
   logic [31:0] mask;
   logic [31:0] sample_m;
   logic [31:0] sat_sum;
   logic [31:0] next_sum;
   logic        next_silent;

   ssm_sat_add u_sat_add (
      .cfg (cfg_ff),
      .a   (sum_ff),
      .b   (in_ff.sample_bits),
      .sum (sat_sum)
   );

   always_comb begin
      // a non-last word needs no result slot, so let it pass a stalled output
      out_free  = !out_valid_ff || rsp_ready;
      proc      = in_valid_ff && (!in_ff.last_stream || out_free);
      emit      = proc && in_ff.last_stream;
      req_ready = !in_valid_ff || proc;

      mask     = width_mask(cfg_ff.sample_width_code);
      sample_m = in_ff.sample_bits & mask;

      // load on first, add on non-gap, skip gaps
      if (in_ff.first_stream) begin
         next_sum    = in_ff.gap_marked ? 32'd0 : sample_m;
         next_silent = in_ff.gap_marked;
      end else if (!in_ff.gap_marked) begin
         next_sum    = sat_sum;
         next_silent = 1'b0;
      end else begin
         next_sum    = sum_ff;
         next_silent = silent_ff;
      end

      // capture a new word when the stage is empty or drains this cycle
      in_valid_in = req_valid || (in_valid_ff && !proc);
      in_in       = (req_valid && req_ready) ? req_payload : in_ff;

      // return to reset values after each emission
      sum_in    = sum_ff;
      silent_in = silent_ff;
      if (proc) begin
         sum_in    = emit ? 32'd0 : next_sum;
         silent_in = emit ? 1'b1 : next_silent;
      end

      out_valid_in = emit || (out_valid_ff && !rsp_ready);
      out_in       = out_ff;
      if (emit) begin
         out_in.mixed_sample = next_sum & mask;
         out_in.all_silent   = next_silent;
      end

      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_WIDTH: cfg_in.sample_width_code = csr_write_data;
            CSR_SIGNED:       cfg_in.signed_samples    = csr_write_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_width_code <= WIDTH_CODE_16;
         cfg_ff.signed_samples    <= 1'b1;
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         sum_ff                   <= 32'd0;
         silent_ff                <= 1'b1;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
         silent_ff    <= silent_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef NO_ASSERTIONS
   // a silent accumulator has nothing in it
   a_silent_sum_zero : assert property (@(posedge clock) disable iff (reset)
      silent_ff |-> (sum_ff == 32'd0))
      else $error("silent accumulator holds a nonzero sum");

   // an all-gap result carries a zero sample
   a_silent_rsp_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.all_silent) |-> (rsp_payload.mixed_sample == 32'd0))
      else $error("silent result word with nonzero sample");

   // emission clears the accumulator
   a_emit_clears : assert property (@(posedge clock) disable iff (reset)
      emit |=> (sum_ff == 32'd0 && silent_ff))
      else $error("accumulator not cleared after emission");

   // an 8-bit result leaves the upper bits clear
   a_width_8_clean : assert property (@(posedge clock) disable iff (reset)
      (emit && cfg_ff.sample_width_code == WIDTH_CODE_8)
         |=> (rsp_payload.mixed_sample[31:8] == 24'd0))
      else $error("8-bit result has bits above its width");

   // a stalled input word is not dropped
   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc) |=> in_valid_ff)
      else $error("stalled input word lost");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/saturating_stream_mixer_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for saturating_stream_mixer_core: a scoreboard class predicts
// each mixed sample word from the accepted input words. Depends on ssm_pkg and the core.

module saturating_stream_mixer_core_test
   import ssm_pkg::*;
();

   // Width code outside the listed ones; the core treats it as 32 bits.
   localparam logic [1:0] WIDTH_CODE_SPARE = 2'd3;

   // Tracks the mixer's accumulator and configuration. Holds the result words it expects.
   class mix_scoreboard;
      logic [1:0]  width_code;
      logic        signed_mode;
      logic [31:0] acc;
      logic        silent;
      ssm_rsp_type mix_expected_q[$];
      int unsigned words_in;
      int unsigned results_seen;
      int unsigned errors;

      function new();
         width_code   = WIDTH_CODE_16;
         signed_mode  = 1'b1;
         acc          = '0;
         silent       = 1'b1;
         words_in     = 0;
         results_seen = 0;
         errors       = 0;
      endfunction

      function void write_reg(logic idx, logic [1:0] data);
         if (idx == CSR_SAMPLE_WIDTH) width_code = data;
         else signed_mode = data[0];
      endfunction

      function logic [31:0] lane_mask();
         case (width_code)
            WIDTH_CODE_8:  return MASK_8;
            WIDTH_CODE_16: return MASK_16;
            default:       return MASK_32;
         endcase
      endfunction

      function logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
         logic [31:0] m;
         longint      ua, ub, sa, sb, half, s;
         m  = lane_mask();
         ua = longint'(a & m);
         ub = longint'(b & m);
         if (signed_mode) begin
            half = (longint'(m) >> 1) + 1;
            sa   = (ua ^ half) - half;
            sb   = (ub ^ half) - half;
            s    = sa + sb;
            if (s > half - 1) s = half - 1;
            if (s < -half) s = -half;
         end else begin
            s = ua + ub;
            if (s > longint'(m)) s = longint'(m);
         end
         return 32'(s) & m;
      endfunction

      function void note_word(ssm_req_type w);
         logic [31:0] m, s;
         ssm_rsp_type r;
         m = lane_mask();
         s = w.sample_bits & m;
         words_in++;
         if (w.first_stream) begin
            acc    = w.gap_marked ? 32'd0 : s;
            silent = w.gap_marked;
         end else if (!w.gap_marked) begin
            acc    = clamp_add(acc, s);
            silent = 1'b0;
         end
         if (w.last_stream) begin
            r.mixed_sample = acc & m;
            r.all_silent   = silent;
            mix_expected_q.push_back(r);
            acc    = '0;
            silent = 1'b1;
         end
      endfunction

      function void check_word(ssm_rsp_type got);
         ssm_rsp_type want;
         results_seen++;
         if (mix_expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result word: sample %h silent %b",
                        got.mixed_sample, got.all_silent);
            return;
         end
         want = mix_expected_q.pop_front();
         if (got.mixed_sample !== want.mixed_sample || got.all_silent !== want.all_silent) begin
            errors++;
            if (errors <= 10)
               $display("result %0d mismatch: expected sample %h silent %b, got %h %b",
                        results_seen, want.mixed_sample, want.all_silent,
                        got.mixed_sample, got.all_silent);
         end
      endfunction

      function int pending();
         return mix_expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ssm_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ssm_rsp_type rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_SAMPLE_WIDTH;
   logic [1:0]  csr_write_data = '0;

   mix_scoreboard sb = new();

   // Chance (percent) that a side goes without idling before its next word.
   int          req_busy_pct = 100;
   int          rsp_busy_pct = 100;
   int          rsp_stall_left = 0;
   int unsigned settings_used = 0;

   always #5 clock = ~clock;

   saturating_stream_mixer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // No gap with the busy chance; otherwise mostly a short gap, rarely a long one.
   function automatic int pick_gap(int busy_pct);
      int r;
      r = $urandom_range(99);
      if (r < busy_pct) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Bias samples toward the edges of the active width; junk rides in the unused upper bits.
   function automatic logic [31:0] pick_sample(logic [31:0] m);
      logic [31:0] junk;
      junk = $urandom;
      case ($urandom_range(7))
         0: return junk;
         1: return (junk & ~m) | m;
         2: return (junk & ~m) | (m >> 1);
         3: return (junk & ~m) | ((m >> 1) + 1);
         4: return junk & ~m;
         5: return (junk & ~m) | 32'd1;
         6: return (junk & ~m) | (m & ~32'hf) | (junk & 32'hf);
         default: return (junk & ~m) | (junk & m & 32'hff);
      endcase
   endfunction

   // Observe both channels and the register port at the rising edge, before any flop updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) sb.write_reg(csr_index, csr_write_data);
         if (req_valid && req_ready) sb.note_word(req_payload);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_payload);
      end
   end

   // Result side backpressure: one ready cycle, then a stall of random length (often none).
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_stall_left = pick_gap(rsp_busy_pct);
         rsp_ready <= 1'b1;
      end
   end

   // Offer one input word; called and returns at a falling edge. Valid stays up
   // between back-to-back words, so it is only lowered when a gap is taken.
   task automatic push_word(ssm_req_type w);
      int gap;
      gap = pick_gap(req_busy_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic push_fields(logic [31:0] s, logic first, logic last, logic gap);
      ssm_req_type w;
      w.sample_bits  = s;
      w.first_stream = first;
      w.last_stream  = last;
      w.gap_marked   = gap;
      push_word(w);
   endtask

   // Drop valid, drain all outstanding results, then give the pipeline time to empty
   // of words that produce no result.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Two register writes on consecutive cycles; the unused data bit of the
   // signedness register is randomized.
   task automatic set_cfg(logic [1:0] code, logic sgn);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SAMPLE_WIDTH;
      csr_write_data   <= code;
      @(negedge clock);
      csr_index        <= CSR_SIGNED;
      csr_write_data   <= {1'($urandom), sgn};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // One sample position across a number of streams. Missing-first positions skip the first
   // marker to test accumulation onto the reset state or onto a sum left open.
   task automatic send_position(int streams, int gap_pct, logic with_first);
      for (int k = 0; k < streams; k++)
         push_fields(pick_sample(sb.lane_mask()), with_first && (k == 0),
                     k == streams - 1, $urandom_range(99) < gap_pct);
   endtask

   initial begin : main
      logic [1:0] code_list [8];
      logic       sign_list [8];
      int         busy_choices [4];
      int         phase_start;
      int         r;
      logic       carry;

      code_list    = '{WIDTH_CODE_8, WIDTH_CODE_8, WIDTH_CODE_16, WIDTH_CODE_32,
                       WIDTH_CODE_32, WIDTH_CODE_SPARE, WIDTH_CODE_SPARE, WIDTH_CODE_16};
      sign_list    = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      busy_choices = '{100, 85, 50, 20};
      carry        = 1'b0;

      // Hold reset, then release it at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at the reset setting (16-bit signed).
      req_busy_pct = 70;
      rsp_busy_pct = 70;
      // single-stream position, then a single gap with junk in the sample
      push_fields(32'h0000_7fff, 1'b1, 1'b1, 1'b0);
      push_fields(32'hffff_ffff, 1'b1, 1'b1, 1'b1);
      // clamp at the positive limit; the trailing gap is skipped
      push_fields(32'h0000_7fff, 1'b1, 1'b0, 1'b0);
      push_fields(32'h0000_0001, 1'b0, 1'b0, 1'b0);
      push_fields(32'h0000_1234, 1'b0, 1'b1, 1'b1);
      // clamp at the negative limit
      push_fields(32'h0000_8000, 1'b1, 1'b0, 1'b0);
      push_fields(32'h0000_ffff, 1'b0, 1'b1, 1'b0);
      // first stream is a gap; upper bits must be ignored
      push_fields(32'hdead_0001, 1'b1, 1'b0, 1'b1);
      push_fields(32'h5555_7ffe, 1'b0, 1'b0, 1'b0);
      push_fields(32'h0000_0000, 1'b0, 1'b1, 1'b0);
      // no first marker: accumulate onto the cleared sum
      push_fields(32'h0000_0005, 1'b0, 1'b0, 1'b0);
      push_fields(32'h0000_0003, 1'b0, 1'b1, 1'b0);
      // every stream silent
      push_fields(32'haaaa_aaaa, 1'b1, 1'b0, 1'b1);
      push_fields(32'h5555_5555, 1'b0, 1'b0, 1'b1);
      push_fields(32'hffff_0000, 1'b0, 1'b1, 1'b1);
      // a second first marker restarts the position
      push_fields(32'h0000_1000, 1'b1, 1'b0, 1'b0);
      push_fields(32'h0000_0200, 1'b1, 1'b0, 1'b0);
      push_fields(32'h0000_0030, 1'b0, 1'b1, 1'b0);
      // minus one plus minus one
      push_fields(32'hffff_ffff, 1'b1, 1'b0, 1'b0);
      push_fields(32'h0000_ffff, 1'b0, 1'b1, 1'b0);

      // Random phases, one per register setting. A phase may end mid-position so that the
      // next setting reads the stored sum in its own width.
      for (int p = 0; p < 8; p++) begin
         settle();
         set_cfg(code_list[p], sign_list[p]);
         req_busy_pct = busy_choices[$urandom_range(3)];
         rsp_busy_pct = busy_choices[$urandom_range(3)];
         if (carry) send_position($urandom_range(1, 2), 20, 1'b0);
         phase_start = sb.words_in;
         while (sb.words_in - phase_start < 100) begin
            r = $urandom_range(99);
            if (r < 60)      send_position($urandom_range(1, 4), 20, 1'b1);
            else if (r < 68) send_position($urandom_range(5, 8), 15, 1'b1);
            else if (r < 75) send_position($urandom_range(1, 4), 100, 1'b1);
            else if (r < 87) send_position($urandom_range(1, 4), 20, 1'b0);
            else push_fields($urandom, 1'($urandom), 1'($urandom), 1'($urandom));
         end
         carry = (p != 7) && ($urandom_range(1) == 1);
         if (carry) send_position($urandom_range(1, 3), 20, 1'b1);
         // leave one word open so the next setting reads the stored sum
         if (carry) push_fields(pick_sample(sb.lane_mask()), 1'b0, 1'b0, 1'b0);
      end

      // Drain and let the pipeline empty before judging.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d input words and %0d result words across %0d register settings",
               sb.words_in, sb.results_seen, settings_used + 1);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("mismatches: %0d", sb.errors);
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legitimate run.
   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("simulation failed");
      $finish;
   end

endmodule
